// ===== src/lgh_pkg.sv =====
`default_nettype none

package lgh_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIST_W  = 16;
  localparam int DPS_W   = 16;
  localparam int DEG_W   = 9;
  localparam int SIDE_W  = 8;
  localparam int ANG_W   = 17;
  localparam int FORCE_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEG_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLOSE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_OFF   = 3'd5;

  localparam logic [DIST_W-1:0] RST_VIEW_DIST  = 16'd1000;
  localparam logic [DIST_W-1:0] RST_CLOSE_DIST = 16'd130;
  localparam logic [DPS_W-1:0]  RST_DEG_STEP   = 16'd16384;
  localparam logic [DEG_W-1:0]  RST_MIN_GAP    = 9'd20;
  localparam logic [DEG_W-1:0]  RST_MIN_CLOSE  = 9'd110;
  localparam logic [SIDE_W-1:0] RST_SIDE_OFF   = 8'd15;

  // -135 degrees in half-sample Q17 units, rounding half, saturation bounds
  localparam int BASE_HALF_Q17 = 135 * 131072;
  localparam int ROUND_HALF    = 256;
  localparam int ROUND_SHIFT   = 9;
  localparam int ANG_MAX       = 65535;
  localparam int ANG_MIN       = -65536;

  localparam logic signed [ANG_W-1:0] NONE_HEADING = 17'sd46080;
  localparam int WIDE_DEG = 30;
  localparam int ROW_DEG  = 180;

  // force magnitude = floor((32*|h| + 7) / 15), clamped
  localparam int Y_W         = 18;
  localparam int FORCE_BIAS  = 7;
  localparam int RCP_W       = 15;
  localparam int RECIP_15    = 17476;
  localparam int RCP_SHIFT   = 18;
  localparam int DIV_BY      = 15;
  localparam int CLAMP_ABS   = 7680;
  localparam int FORCE_MAX   = 16384;

  typedef struct packed {
    logic [DIST_W-1:0] view_dist;
    logic [DIST_W-1:0] close_dist;
    logic [DPS_W-1:0]  deg_step;
    logic [DEG_W-1:0]  min_gap;
    logic [DEG_W-1:0]  min_close;
    logic [SIDE_W-1:0] side_off;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_FAR,
    MUL_NEAR,
    MUL_CENTER,
    MUL_EDGE_LO,
    MUL_EDGE_HI,
    MUL_BEST
  } mul_sel_e;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     cmp_far;
    logic     ang_center;
    logic     ang_edge_lo;
    logic     ang_edge_hi;
    logic     take_best;
    logic     advance;
    logic     out_mul;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic qualify;
    logic wide;
    logic last;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/lidar_gap_heading_finder.sv =====
`default_nettype none

// Channel  Handshake               Payload
// in       in_valid_i/in_ready_o   range_mm_i, last_sample_i
// out      out_valid_o/out_ready_i steer_force_o, heading_angle_o, row_exit_o, blocked_o
// cfg      cfg_we_i                cfg_idx_i, cfg_data_i
//
// Samples run ST_MUL_FAR, ST_MUL_NEAR, ST_CHECK; closing a qualifying gap adds ST_CENTER
// and ST_UPDATE, a wide gap also ST_EDGE_LO and ST_EDGE_HI, in turn on the shared
// multiplier, used once per cycle; a scan's last sample adds ST_OUT_MUL and ST_OUT_LOAD.
// Reset restores the register defaults and clears the scan state at once.
// A held result stalls the input only once the next scan's result is ready to load.

module lidar_gap_heading_finder #(
  parameter int MAX_SAMPLES = 4096,
  parameter int RANGE_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lgh_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [lgh_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [RANGE_BITS-1:0]                range_mm_i,
  input  logic                                 last_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [lgh_pkg::FORCE_W-1:0]   steer_force_o,
  output logic signed [lgh_pkg::ANG_W-1:0]     heading_angle_o,
  output logic                                 row_exit_o,
  output logic                                 blocked_o
);
  import lgh_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  lgh_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lgh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lgh_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .RANGE_BITS  (RANGE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .range_mm_i      (range_mm_i),
    .last_sample_i   (last_sample_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .steer_force_o   (steer_force_o),
    .heading_angle_o (heading_angle_o),
    .row_exit_o      (row_exit_o),
    .blocked_o       (blocked_o)
  );

endmodule

`default_nettype wire

// ===== src/lgh_cfg.sv =====
`default_nettype none

module lgh_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lgh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lgh_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output lgh_pkg::cfg_t                      cfg_o
);
  import lgh_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VIEW_DIST:  cfg_d.view_dist  = cfg_data_i[DIST_W-1:0];
        CFG_CLOSE_DIST: cfg_d.close_dist = cfg_data_i[DIST_W-1:0];
        CFG_DEG_STEP:   cfg_d.deg_step   = cfg_data_i[DPS_W-1:0];
        CFG_MIN_GAP:    cfg_d.min_gap    = cfg_data_i[DEG_W-1:0];
        CFG_MIN_CLOSE:  cfg_d.min_close  = cfg_data_i[DEG_W-1:0];
        CFG_SIDE_OFF:   cfg_d.side_off   = cfg_data_i[SIDE_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view_dist  <= RST_VIEW_DIST;
      cfg_q.close_dist <= RST_CLOSE_DIST;
      cfg_q.deg_step   <= RST_DEG_STEP;
      cfg_q.min_gap    <= RST_MIN_GAP;
      cfg_q.min_close  <= RST_MIN_CLOSE;
      cfg_q.side_off   <= RST_SIDE_OFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/lgh_ctrl.sv =====
`default_nettype none

module lgh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lgh_pkg::stat_t stat_i,
  output lgh_pkg::cmd_t  cmd_o
);
  import lgh_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_FAR,
    ST_MUL_NEAR,
    ST_CHECK,
    ST_CENTER,
    ST_EDGE_LO,
    ST_EDGE_HI,
    ST_UPDATE,
    ST_OUT_MUL,
    ST_OUT_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.mul_sel = MUL_FAR;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd.accept = 1'b1;
          state_d    = ST_MUL_FAR;
        end
      end
      ST_MUL_FAR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FAR;
        state_d     = ST_MUL_NEAR;
      end
      ST_MUL_NEAR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_NEAR;
        cmd.cmp_far = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CENTER;
        if (stat_i.qualify) begin
          state_d = ST_CENTER;
        end else begin
          cmd.advance = 1'b1;
          state_d     = stat_i.last ? ST_OUT_MUL : ST_IDLE;
        end
      end
      ST_CENTER: begin
        cmd.ang_center = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = MUL_EDGE_LO;
        state_d        = stat_i.wide ? ST_EDGE_LO : ST_UPDATE;
      end
      ST_EDGE_LO: begin
        cmd.ang_edge_lo = 1'b1;
        cmd.mul_en      = 1'b1;
        cmd.mul_sel     = MUL_EDGE_HI;
        state_d         = ST_EDGE_HI;
      end
      ST_EDGE_HI: begin
        cmd.ang_edge_hi = 1'b1;
        state_d         = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.take_best = 1'b1;
        cmd.advance   = 1'b1;
        state_d       = stat_i.last ? ST_OUT_MUL : ST_IDLE;
      end
      ST_OUT_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BEST;
        cmd.out_mul = 1'b1;
        state_d     = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        if (!stat_i.out_busy) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    in_ready_d = (state_d == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= in_ready_d;
    end
  end

  assign in_ready_o = in_ready_q;
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

// ===== src/lgh_dp.sv =====
`default_nettype none

module lgh_dp #(
  parameter int MAX_SAMPLES = 4096,
  parameter int RANGE_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lgh_pkg::cfg_t                         cfg_i,
  input  lgh_pkg::cmd_t                         cmd_i,
  output lgh_pkg::stat_t                        stat_o,
  input  logic [RANGE_BITS-1:0]                 range_mm_i,
  input  logic                                  last_sample_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [lgh_pkg::FORCE_W-1:0]    steer_force_o,
  output logic signed [lgh_pkg::ANG_W-1:0]      heading_angle_o,
  output logic                                  row_exit_o,
  output logic                                  blocked_o
);
  import lgh_pkg::*;

  localparam int IDX_W   = $clog2(MAX_SAMPLES);
  localparam int CMP_W   = (RANGE_BITS > DIST_W) ? RANGE_BITS : DIST_W;
  localparam int P_W     = ((IDX_W > SIDE_W) ? IDX_W : SIDE_W) + 3;
  localparam int PROD_W  = P_W + DPS_W + 1;
  localparam int V_W     = ((PROD_W > 26) ? PROD_W : 26) + 1;
  localparam int RP_W    = Y_W + RCP_W;
  localparam int Q_W     = RP_W - RCP_SHIFT;
  localparam int R_W     = Y_W + 1;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);

  function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] v);
    sat_inc = (v < IDX_MAX) ? v + IDX_W'(1) : v;
  endfunction

  function automatic logic [ANG_W-1:0] abs_ang(input logic signed [ANG_W-1:0] a);
    abs_ang = a[ANG_W-1] ? -a : a;
  endfunction

  function automatic logic signed [V_W-1:0] deg_limit(input logic [DEG_W-1:0] deg);
    deg_limit = $signed(V_W'({deg, 16'h0000}));
  endfunction

  function automatic logic signed [ANG_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] t;
    v = V_W'(p) - V_W'(BASE_HALF_Q17) + V_W'(ROUND_HALF);
    t = v >>> ROUND_SHIFT;
    if (t > V_W'(ANG_MAX)) begin
      round_sat = ANG_W'(ANG_MAX);
    end else if (t < V_W'(ANG_MIN)) begin
      round_sat = ANG_W'(ANG_MIN);
    end else begin
      round_sat = t[ANG_W-1:0];
    end
  endfunction

  // scan state
  logic [IDX_W-1:0]        idx_q;
  logic [IDX_W-1:0]        far_run_q;
  logic [IDX_W-1:0]        near_run_q;
  logic [IDX_W-1:0]        best_run_q;
  logic signed [ANG_W-1:0] best_q;
  logic                    out_valid_q;

  // per-sample working registers
  logic                    far_q, near_q, last_q;
  logic                    qual_far_q, wide_q;
  logic signed [PROD_W-1:0] mul_q;
  logic signed [ANG_W-1:0] ang_q;
  logic [RP_W-1:0]         recip_q;

  logic signed [FORCE_W-1:0] out_force_q;
  logic signed [ANG_W-1:0]   out_heading_q;
  logic                      out_row_q;
  logic                      out_blocked_q;

  logic                    far, near_free;
  logic signed [P_W-1:0]   mul_a;
  logic signed [P_W-1:0]   two_i, two_h, two_off;
  logic signed [DPS_W:0]   mul_b;
  logic signed [ANG_W-1:0] ang_new;
  logic [ANG_W-1:0]        abs_best;
  logic                    clamp;
  logic [Y_W-1:0]          y;
  logic [Q_W-1:0]          q0, q;
  logic [R_W-1:0]          rem;
  logic signed [FORCE_W-1:0] mag, force_v;

  assign far       = CMP_W'(range_mm_i) > CMP_W'(cfg_i.view_dist);
  assign near_free = CMP_W'(range_mm_i) > CMP_W'(cfg_i.close_dist);

  assign two_i   = $signed(P_W'({idx_q, 1'b0}));
  assign two_h   = $signed(P_W'({far_run_q, 1'b0}));
  assign two_off = $signed(P_W'({cfg_i.side_off, 1'b0}));
  assign mul_b   = $signed({1'b0, cfg_i.deg_step});

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_FAR:     mul_a = $signed(P_W'(far_run_q));
      MUL_NEAR:    mul_a = $signed(P_W'(near_run_q));
      MUL_CENTER:  mul_a = two_i - $signed(P_W'(far_run_q));
      MUL_EDGE_LO: mul_a = two_i - two_off;
      MUL_EDGE_HI: mul_a = two_i - two_h + two_off;
      MUL_BEST:    mul_a = $signed(P_W'(best_run_q));
      default:     mul_a = '0;
    endcase
  end

  assign ang_new = round_sat(mul_q);

  assign stat_o.qualify  = (!far_q || last_q) && qual_far_q
                           && (V_W'(mul_q) > deg_limit(cfg_i.min_close));
  assign stat_o.wide     = wide_q;
  assign stat_o.last     = last_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  // force magnitude from the stored heading
  assign abs_best = abs_ang(best_q);
  assign clamp    = abs_best >= ANG_W'(CLAMP_ABS);
  assign y        = {abs_best[Y_W-6:0], 5'b00000} + Y_W'(FORCE_BIAS);
  assign q0       = recip_q[RP_W-1:RCP_SHIFT];
  assign rem      = R_W'(y) - R_W'(q0) * R_W'(DIV_BY);
  assign q        = (rem >= R_W'(DIV_BY)) ? q0 + Q_W'(1) : q0;
  assign mag      = clamp ? FORCE_W'(FORCE_MAX) : FORCE_W'(q);
  assign force_v  = (!best_q[ANG_W-1] && (best_q != '0)) ? -mag : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      far_run_q   <= '0;
      near_run_q  <= '0;
      best_run_q  <= '0;
      best_q      <= NONE_HEADING;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (far) begin
          far_run_q <= sat_inc(far_run_q);
        end
        if (near_free) begin
          near_run_q <= sat_inc(near_run_q);
        end
      end
      if (cmd_i.take_best && (abs_ang(ang_q) < abs_ang(best_q))) begin
        best_run_q <= far_run_q;
        best_q     <= ang_q;
      end
      if (cmd_i.advance) begin
        if (!far_q) begin
          far_run_q <= '0;
        end
        if (!near_q) begin
          near_run_q <= '0;
        end
        idx_q <= sat_inc(idx_q);
      end
      if (cmd_i.load_out) begin
        idx_q       <= '0;
        far_run_q   <= '0;
        near_run_q  <= '0;
        best_run_q  <= '0;
        best_q      <= NONE_HEADING;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      far_q  <= far;
      near_q <= near_free;
      last_q <= last_sample_i;
    end
    if (cmd_i.mul_en) begin
      mul_q <= mul_a * mul_b;
    end
    if (cmd_i.cmp_far) begin
      qual_far_q <= V_W'(mul_q) > deg_limit(cfg_i.min_gap);
      wide_q     <= V_W'(mul_q) > deg_limit(DEG_W'(WIDE_DEG));
    end
    if (cmd_i.ang_center) begin
      ang_q <= ang_new;
    end
    if (cmd_i.ang_edge_lo && (abs_ang(ang_new) < abs_ang(ang_q))) begin
      ang_q <= ang_new;
    end
    if (cmd_i.ang_edge_hi) begin
      if ((ang_new < 0 && ang_q > 0) || (ang_new > 0 && ang_q < 0)) begin
        ang_q <= '0;
      end else if (abs_ang(ang_new) < abs_ang(ang_q)) begin
        ang_q <= ang_new;
      end
    end
    if (cmd_i.out_mul) begin
      recip_q <= RP_W'(y) * RP_W'(RECIP_15);
    end
    if (cmd_i.load_out) begin
      out_force_q   <= force_v;
      out_heading_q <= best_q;
      out_row_q     <= V_W'(mul_q) > deg_limit(DEG_W'(ROW_DEG));
      out_blocked_q <= (best_run_q == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign steer_force_o   = out_force_q;
  assign heading_angle_o = out_heading_q;
  assign row_exit_o      = out_row_q;
  assign blocked_o       = out_blocked_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench;
  import lgh_pkg::*;

  localparam int SETTLE_CYCLES = 20;

  typedef enum int {
    K_BLOCKED,
    K_NEAR,
    K_FAR,
    K_ANY
  } sample_kind_e;

  typedef struct {
    logic signed [FORCE_W-1:0] steer;
    logic signed [ANG_W-1:0]   heading;
    logic                      end_row;
    logic                      blocked;
  } steer_result_t;

  class heading_scoreboard;
    cfg_t          regs;
    int unsigned   scan_idx;
    int unsigned   far_run;
    int unsigned   near_run;
    int unsigned   best_run;
    int            best_heading;
    steer_result_t awaited[$];
    int            errors;

    function new();
      regs.view_dist  = 16'd1000;
      regs.close_dist = 16'd130;
      regs.deg_step   = 16'd16384;
      regs.min_gap    = 9'd20;
      regs.min_close  = 9'd110;
      regs.side_off   = 8'd15;
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      scan_idx     = 0;
      far_run      = 0;
      near_run     = 0;
      best_run     = 0;
      best_heading = 46080;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VIEW_DIST:  regs.view_dist  = data;
        CFG_CLOSE_DIST: regs.close_dist = data;
        CFG_DEG_STEP:   regs.deg_step   = data;
        CFG_MIN_GAP:    regs.min_gap    = data[DEG_W-1:0];
        CFG_MIN_CLOSE:  regs.min_close  = data[DEG_W-1:0];
        CFG_SIDE_OFF:   regs.side_off   = data[SIDE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned bump(int unsigned v);
      return (v < 4095) ? v + 1 : v;
    endfunction

    function int iabs(int a);
      return (a < 0) ? -a : a;
    endfunction

    // angle of a position given in half samples, Q8.8, round half up, saturate
    function int angle_at(longint half_pos);
      longint v;
      v = half_pos * longint'(regs.deg_step) - longint'(135 * 131072) + 256;
      v = v >>> 9;
      if (v > 65535) v = 65535;
      if (v < -65536) v = -65536;
      return int'(v);
    endfunction

    function bit wider(int unsigned run, int unsigned deg);
      return longint'(run) * longint'(regs.deg_step) > (longint'(deg) << 16);
    endfunction

    function void note_sample(logic [15:0] rng, logic last);
      bit            is_far;
      bit            is_free;
      longint        i;
      longint        h;
      longint        off;
      int            a;
      int            a2;
      int            a3;
      int            mag;
      steer_result_t r;
      is_far  = rng > regs.view_dist;
      is_free = rng > regs.close_dist;
      i = scan_idx;
      if (is_free) near_run = bump(near_run);
      if (is_far) far_run = bump(far_run);
      if ((!is_far || last) && wider(far_run, regs.min_gap)
          && wider(near_run, regs.min_close)) begin
        h = far_run;
        a = angle_at(2 * i - h);
        if (wider(far_run, 30)) begin
          off = longint'(regs.side_off);
          a2 = angle_at(2 * (i - off));
          if (iabs(a2) < iabs(a)) a = a2;
          a3 = angle_at(2 * (i - h + off));
          if ((a3 < 0 && a > 0) || (a3 > 0 && a < 0)) begin
            a = 0;
          end else if (iabs(a3) < iabs(a)) begin
            a = a3;
          end
        end
        if (iabs(a) < iabs(best_heading)) begin
          best_run     = far_run;
          best_heading = a;
        end
      end
      if (!is_far) far_run = 0;
      if (!is_free) near_run = 0;
      scan_idx = bump(scan_idx);
      if (last) begin
        mag = (iabs(best_heading) * 64 + 15) / 30;
        if (mag > 16384) mag = 16384;
        r.steer   = FORCE_W'((best_heading > 0) ? -mag : mag);
        r.heading = ANG_W'(best_heading);
        r.end_row = wider(best_run, 180);
        r.blocked = (best_run == 0);
        awaited.push_back(r);
        clear_scan();
      end
    endfunction

    function void mismatch(string what, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    endfunction

    function void check_result(logic signed [FORCE_W-1:0] steer,
                               logic signed [ANG_W-1:0] heading,
                               logic end_row, logic blocked);
      steer_result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none actual heading %0d", $time, heading);
        errors++;
        return;
      end
      r = awaited.pop_front();
      if (steer !== r.steer) mismatch("steer_force", r.steer, steer);
      if (heading !== r.heading) mismatch("heading_angle", r.heading, heading);
      if (end_row !== r.end_row) mismatch("row_exit", r.end_row, end_row);
      if (blocked !== r.blocked) mismatch("blocked", r.blocked, blocked);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  logic [15:0]                  range_mm_i    = '0;
  logic                         last_sample_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  logic signed [FORCE_W-1:0]    steer_force_o;
  logic signed [ANG_W-1:0]      heading_angle_o;
  logic                         row_exit_o;
  logic                         blocked_o;

  heading_scoreboard sb = new();

  bit          idle_in   = 1'b1;
  bit          idle_out  = 1'b1;
  bit          valid_up  = 1'b0;
  int unsigned gap_ahead = 0;
  int unsigned items_sent = 0;

  lidar_gap_heading_finder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .range_mm_i     (range_mm_i),
    .last_sample_i  (last_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .steer_force_o  (steer_force_o),
    .heading_angle_o(heading_angle_o),
    .row_exit_o     (row_exit_o),
    .blocked_o      (blocked_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic cfg_t settings(int unsigned view, int unsigned close, int unsigned step,
                                    int unsigned gap, int unsigned close_gap,
                                    int unsigned side);
    cfg_t s;
    s.view_dist  = DIST_W'(view);
    s.close_dist = DIST_W'(close);
    s.deg_step   = DPS_W'(step);
    s.min_gap    = DEG_W'(gap);
    s.min_close  = DEG_W'(close_gap);
    s.side_off   = SIDE_W'(side);
    return s;
  endfunction

  function automatic cfg_t phase_settings(int p);
    cfg_t s;
    case (p)
      0: s = settings(1000, 130, 65535, 5, 10, 15);
      1: s = settings(1000, 130, 61440, 0, 0, 0);
      2: s = settings(65535, 0, 40000, 0, 0, 0);
      3: s = settings(0, 65535, 30000, 0, 0, 255);
      4: s = settings(2000, 100, 65535, 270, 270, 15);
      5: s = settings(500, 499, 1, 0, 0, 8);
      default: begin
        s.view_dist  = DIST_W'($urandom_range(0, 4000));
        s.close_dist = DIST_W'($urandom_range(0, s.view_dist));
        s.deg_step   = DPS_W'($urandom_range(20000, 65535));
        s.min_gap    = DEG_W'($urandom_range(0, 30));
        s.min_close  = DEG_W'($urandom_range(0, 80));
        s.side_off   = SIDE_W'($urandom_range(0, 255));
      end
    endcase
    return s;
  endfunction

  function automatic logic [15:0] pick_range(sample_kind_e kind);
    int unsigned lo;
    int unsigned hi;
    case (kind)
      K_BLOCKED: begin
        lo = 0;
        hi = sb.regs.close_dist;
      end
      K_NEAR: begin
        lo = sb.regs.close_dist + 1;
        hi = sb.regs.view_dist;
      end
      K_FAR: begin
        lo = sb.regs.view_dist + 1;
        hi = 65535;
      end
      default: begin
        lo = 0;
        hi = 65535;
      end
    endcase
    if (lo > hi) begin
      lo = 0;
      hi = 65535;
    end
    case ($urandom_range(0, 7))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic sample_kind_e draw_kind();
    int unsigned d;
    d = $urandom_range(0, 9);
    if (d < 4) return K_FAR;
    if (d < 7) return K_NEAR;
    if (d < 9) return K_BLOCKED;
    return K_ANY;
  endfunction

  task automatic send_sample(logic [15:0] rng, logic last);
    repeat (gap_ahead) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    range_mm_i    <= rng;
    last_sample_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_sample(rng, last);
    items_sent++;
    gap_ahead = idle_in ? $urandom_range(0, 8) : 0;
    valid_up  = (gap_ahead == 0);
    if (!valid_up) in_valid_i <= 1'b0;
  endtask

  task automatic pause_input();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    gap_ahead = 0;
  endtask

  task automatic wait_drained();
    pause_input();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_settings(cfg_t s);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_register(CFG_VIEW_DIST, s.view_dist);
    write_register(CFG_CLOSE_DIST, s.close_dist);
    write_register(CFG_DEG_STEP, s.deg_step);
    write_register(CFG_MIN_GAP, CFG_DATA_W'(s.min_gap));
    write_register(CFG_MIN_CLOSE, CFG_DATA_W'(s.min_close));
    write_register(CFG_SIDE_OFF, CFG_DATA_W'(s.side_off));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_runs(sample_kind_e kind, int count, bit ends_scan);
    for (int n = 0; n < count; n++) begin
      send_sample(pick_range(kind), ends_scan && (n == count - 1));
    end
  endtask

  task automatic random_scan();
    int           len;
    int           left;
    sample_kind_e kind;
    if ($urandom_range(0, 7) == 0) wait_drained();
    idle_in  = ($urandom_range(0, 3) != 0);
    idle_out = ($urandom_range(0, 3) != 0);
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
    left = 0;
    kind = K_ANY;
    for (int n = 0; n < len; n++) begin
      if (left == 0) begin
        kind = draw_kind();
        left = $urandom_range(1, (len > 30) ? 40 : 6);
      end
      send_sample(pick_range(kind), n == len - 1);
      left--;
    end
  endtask

  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = idle_out ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(steer_force_o, heading_angle_o, row_exit_o, blocked_o);
    end
  end

  initial begin : stimulus
    int unsigned phase_start;
    int          phase_scans;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(16'd0, 1'b1);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1001, 1'b0);
    send_sample(16'd130, 1'b0);
    send_sample(16'd131, 1'b0);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd0, 1'b1);

    apply_settings(settings(0, 0, 65535, 0, 0, 0));
    send_sample(16'd1, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd65535, 1'b1);

    apply_settings(settings(1000, 130, 0, 0, 0, 255));
    send_sample(16'd5000, 1'b0);
    send_sample(16'd5000, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd5000, 1'b1);

    apply_settings(settings(65535, 65535, 65535, 270, 270, 255));
    send_sample(16'd65535, 1'b0);
    send_sample(16'd0, 1'b1);

    // two gaps mirrored about straight ahead: the first one must stay
    apply_settings(settings(1000, 130, 61440, 0, 0, 15));
    send_runs(K_NEAR, 133, 1'b0);
    send_runs(K_FAR, 2, 1'b0);
    send_runs(K_NEAR, 18, 1'b0);
    send_runs(K_FAR, 2, 1'b0);
    send_runs(K_NEAR, 6, 1'b1);
    send_runs(K_FAR, 200, 1'b1);

    for (int p = 0; p < 7; p++) begin
      apply_settings(phase_settings(p));
      phase_start = items_sent;
      phase_scans = 0;
      while (items_sent - phase_start < 20 || phase_scans < 2) begin
        random_scan();
        phase_scans++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lgh_pkg.sv
src/lgh_cfg.sv
src/lgh_ctrl.sv
src/lgh_dp.sv
src/lidar_gap_heading_finder.sv
tb/sv/testbench.sv
